>>> design/iee_pkg.sv
package iee_pkg;

    localparam int FRACTION_BITS_DEF       = 32;
    localparam int MAX_FRACTION_DIGITS_DEF = 9;
    localparam int QUEUE_DEPTH             = 2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIV0    = 2'd1;
    localparam logic [1:0] ST_OPERAND = 2'd2;
    localparam logic [1:0] ST_OVF     = 2'd3;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // largest mantissa that still takes one more digit
    localparam logic [63:0] ACC_LIMIT = 64'h1999_9999_9999_9998;
    localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
    } out_word_t;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_DOT,
        TK_SPACE,
        TK_OP,
        TK_OTHER
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] code;
        logic       last;
    } token_t;

    typedef enum logic [1:0] {
        AR_MUL,
        AR_DIV,
        AR_CONV
    } arith_kind_t;

    typedef struct packed {
        arith_kind_t kind;
        logic [63:0] a;
        logic [63:0] b;
    } arith_req_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } arith_rsp_t;

    function automatic logic [63:0] mag64(input logic [63:0] x);
        mag64 = x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] pow10(input logic [3:0] k);
        unique case (k)
            4'd0:  pow10 = 64'd1;
            4'd1:  pow10 = 64'd10;
            4'd2:  pow10 = 64'd100;
            4'd3:  pow10 = 64'd1000;
            4'd4:  pow10 = 64'd10000;
            4'd5:  pow10 = 64'd100000;
            4'd6:  pow10 = 64'd1000000;
            4'd7:  pow10 = 64'd10000000;
            4'd8:  pow10 = 64'd100000000;
            4'd9:  pow10 = 64'd1000000000;
            4'd10: pow10 = 64'd10000000000;
            4'd11: pow10 = 64'd100000000000;
            4'd12: pow10 = 64'd1000000000000;
            4'd13: pow10 = 64'd10000000000000;
            4'd14: pow10 = 64'd100000000000000;
            4'd15: pow10 = 64'd1000000000000000;
        endcase
    endfunction

endpackage

>>> design/iee_front.sv
module iee_front (
    input  logic              push,
    input  iee_pkg::in_word_t item,
    input  logic              queue_full,
    output logic              full,
    output logic              wr,
    output iee_pkg::token_t   token
);

    always_comb
    begin
        token.last = item.last;
        token.code = 4'd0;
        if (item.ch >= iee_pkg::CH_ZERO && item.ch <= iee_pkg::CH_NINE)
        begin
            token.kind = iee_pkg::TK_DIGIT;
            token.code = item.ch[3:0];
        end
        else if (item.ch == iee_pkg::CH_DOT)
            token.kind = iee_pkg::TK_DOT;
        else if (item.ch == iee_pkg::CH_SPACE)
            token.kind = iee_pkg::TK_SPACE;
        else if (item.ch == iee_pkg::CH_PLUS)
        begin
            token.kind = iee_pkg::TK_OP;
            token.code = {2'b00, iee_pkg::OP_ADD};
        end
        else if (item.ch == iee_pkg::CH_MINUS)
        begin
            token.kind = iee_pkg::TK_OP;
            token.code = {2'b00, iee_pkg::OP_SUB};
        end
        else if (item.ch == iee_pkg::CH_STAR)
        begin
            token.kind = iee_pkg::TK_OP;
            token.code = {2'b00, iee_pkg::OP_MUL};
        end
        else if (item.ch == iee_pkg::CH_SLASH)
        begin
            token.kind = iee_pkg::TK_OP;
            token.code = {2'b00, iee_pkg::OP_DIV};
        end
        else
            token.kind = iee_pkg::TK_OTHER;
    end

    assign full = queue_full;
    // drop spaces that do not end the expression
    assign wr = push && !queue_full && !(token.kind == iee_pkg::TK_SPACE && !item.last);

endmodule

>>> design/iee_queue.sv
module iee_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  iee_pkg::token_t wdata,
    output logic            full,
    input  logic            rd,
    output iee_pkg::token_t rdata,
    output logic            empty
);

    // depth is a power of two so the pointers wrap on their own
    localparam int AW = $clog2(iee_pkg::QUEUE_DEPTH);

    iee_pkg::token_t  mem_reg [iee_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [AW:0]      count_reg;

    assign full  = (count_reg == (AW+1)'(iee_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                mem_reg[wptr_reg] <= wdata;
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd)
                rptr_reg <= rptr_reg + 1'b1;
            if (wr && !rd)
                count_reg <= count_reg + 1'b1;
            else if (rd && !wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> design/iee_arith.sv
module iee_arith #(
    parameter int FRACTION_BITS = iee_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  iee_pkg::arith_req_t req,
    output logic                done,
    output iee_pkg::arith_rsp_t rsp
);

    localparam int NW = 64 + FRACTION_BITS;
    localparam int CW = $clog2(NW);

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_ROUND,
        A_SIGN
    } mode_t;

    mode_t                mode_reg;
    iee_pkg::arith_kind_t kind_reg;
    logic                 neg_reg;
    logic [CW-1:0]        cnt_reg;
    logic [127:0]         prod_reg;
    logic [63:0]          opnd_reg;
    logic [NW-1:0]        num_reg;
    logic [63:0]          rem_reg;
    logic [63:0]          q_reg;
    logic                 ovf_reg;
    logic [63:0]          mag_reg;
    logic                 done_reg;
    iee_pkg::arith_rsp_t  rsp_reg;

    logic [64:0] sum;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;
    logic [CW-1:0] lim;
    logic [63:0] mq;
    logic        rbit;
    logic        rovf;

    always_comb
    begin
        sum   = {1'b0, prod_reg[127:64]} + {1'b0, (prod_reg[0] ? opnd_reg : 64'd0)};
        trial = {rem_reg, num_reg[NW-1]};
        diff  = trial - {1'b0, opnd_reg};
        ge    = (trial >= {1'b0, opnd_reg});
        // a quotient bit at or above this index means the result cannot fit
        lim   = (kind_reg == iee_pkg::AR_CONV) ? CW'(63) : CW'(64);
        if (kind_reg == iee_pkg::AR_MUL)
        begin
            mq   = prod_reg[FRACTION_BITS+63 -: 64];
            rbit = prod_reg[FRACTION_BITS-1];
            rovf = (|prod_reg[127 -: (64-FRACTION_BITS)]) || (&mq && rbit);
        end
        else
        begin
            mq   = q_reg;
            rbit = ({rem_reg, 1'b0} >= {1'b0, opnd_reg});
            rovf = ovf_reg || (kind_reg == iee_pkg::AR_DIV && &q_reg && rbit);
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= A_IDLE;
            kind_reg <= iee_pkg::AR_MUL;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            prod_reg <= '0;
            opnd_reg <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
            mag_reg  <= '0;
            done_reg <= 1'b0;
            rsp_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (mode_reg)
                A_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg <= req.kind;
                        rem_reg  <= '0;
                        q_reg    <= '0;
                        ovf_reg  <= 1'b0;
                        unique case (req.kind)
                            iee_pkg::AR_MUL:
                            begin
                                neg_reg  <= req.a[63] ^ req.b[63];
                                prod_reg <= {64'd0, iee_pkg::mag64(req.b)};
                                opnd_reg <= iee_pkg::mag64(req.a);
                                cnt_reg  <= CW'(63);
                                mode_reg <= A_MUL;
                            end
                            iee_pkg::AR_DIV:
                            begin
                                neg_reg  <= req.a[63] ^ req.b[63];
                                opnd_reg <= iee_pkg::mag64(req.b);
                                num_reg  <= {iee_pkg::mag64(req.a), {FRACTION_BITS{1'b0}}};
                                cnt_reg  <= CW'(NW-1);
                                if (req.b == 64'd0)
                                begin
                                    rsp_reg  <= {64'd0, iee_pkg::ST_DIV0};
                                    done_reg <= 1'b1;
                                end
                                else
                                    mode_reg <= A_DIV;
                            end
                            default:
                            begin
                                neg_reg  <= 1'b0;
                                opnd_reg <= req.b;
                                num_reg  <= {req.a, {FRACTION_BITS{1'b0}}};
                                cnt_reg  <= CW'(NW-1);
                                mode_reg <= A_DIV;
                            end
                        endcase
                    end
                end
                A_MUL:
                begin
                    prod_reg <= {sum, prod_reg[63:1]};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        mode_reg <= A_ROUND;
                end
                A_DIV:
                begin
                    rem_reg <= ge ? diff[63:0] : trial[63:0];
                    q_reg   <= {q_reg[62:0], ge};
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                    if (ge && cnt_reg >= lim)
                        ovf_reg <= 1'b1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        mode_reg <= A_ROUND;
                end
                A_ROUND:
                begin
                    mag_reg  <= mq + {63'd0, rbit};
                    ovf_reg  <= rovf;
                    mode_reg <= A_SIGN;
                end
                A_SIGN:
                begin
                    if (ovf_reg)
                        rsp_reg <= {64'd0, iee_pkg::ST_OVF};
                    else if (neg_reg)
                    begin
                        if (mag_reg > iee_pkg::SIGN_BIT)
                            rsp_reg <= {64'd0, iee_pkg::ST_OVF};
                        else
                            rsp_reg <= {64'd0 - mag_reg, iee_pkg::ST_OK};
                    end
                    else if (mag_reg[63])
                        rsp_reg <= {64'd0, iee_pkg::ST_OVF};
                    else
                        rsp_reg <= {mag_reg, iee_pkg::ST_OK};
                    done_reg <= 1'b1;
                    mode_reg <= A_IDLE;
                end
                default:
                    mode_reg <= A_IDLE;
            endcase
        end
    end

endmodule

>>> design/iee_back.sv
module iee_back #(
    parameter int MAX_FRACTION_DIGITS = iee_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  iee_pkg::token_t      q_data,
    output logic                 q_rd,
    output logic                 ar_start,
    output iee_pkg::arith_req_t  ar_req,
    input  logic                 ar_done,
    input  iee_pkg::arith_rsp_t  ar_rsp,
    output logic                 empty,
    input  logic                 pop,
    output iee_pkg::out_word_t   result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAKE,
        S_ENDTOK,
        S_CLOSE,
        S_CONV,
        S_OPRED,
        S_FINRED,
        S_REDUCE,
        S_ARITH,
        S_OUT
    } state_t;

    state_t              state_reg;
    iee_pkg::token_t     tok_reg;
    logic                final_reg;
    logic [63:0]         stk0_reg;
    logic [63:0]         stk1_reg;
    logic [63:0]         stk2_reg;
    logic [1:0]          vcnt_reg;
    logic [1:0]          op0_reg;
    logic [1:0]          op1_reg;
    logic [1:0]          ocnt_reg;
    logic [63:0]         acc_reg;
    logic [3:0]          fdc_reg;
    logic                dseen_reg;
    logic                pend_reg;
    logic [1:0]          err_reg;
    logic                start_reg;
    iee_pkg::arith_req_t req_reg;
    logic                out_valid_reg;
    iee_pkg::out_word_t  out_reg;

    logic [63:0] acc_x10;
    logic [63:0] add_s;
    logic [63:0] sub_s;
    logic        add_ovf;
    logic        sub_ovf;
    state_t      red_ret;

    always_comb
    begin
        acc_x10 = (acc_reg << 3) + (acc_reg << 1) + {60'd0, tok_reg.code};
        add_s   = stk1_reg + stk0_reg;
        sub_s   = stk1_reg - stk0_reg;
        add_ovf = (stk1_reg[63] == stk0_reg[63]) && (add_s[63] != stk1_reg[63]);
        sub_ovf = (stk1_reg[63] != stk0_reg[63]) && (sub_s[63] != stk1_reg[63]);
        red_ret = final_reg ? S_FINRED : S_OPRED;
    end

    assign q_rd     = (state_reg == S_IDLE) && !q_empty;
    assign ar_start = start_reg;
    assign ar_req   = req_reg;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tok_reg       <= '0;
            final_reg     <= 1'b0;
            stk0_reg      <= '0;
            stk1_reg      <= '0;
            stk2_reg      <= '0;
            vcnt_reg      <= '0;
            op0_reg       <= '0;
            op1_reg       <= '0;
            ocnt_reg      <= '0;
            acc_reg       <= '0;
            fdc_reg       <= '0;
            dseen_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            err_reg       <= iee_pkg::ST_OK;
            start_reg     <= 1'b0;
            req_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            // the output step reloads the word itself
            if (pop && out_valid_reg && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        tok_reg   <= q_data;
                        state_reg <= S_TAKE;
                    end
                end
                S_TAKE:
                begin
                    state_reg <= S_ENDTOK;
                    if (err_reg == iee_pkg::ST_OK)
                    begin
                        unique case (tok_reg.kind)
                            iee_pkg::TK_DIGIT:
                            begin
                                pend_reg <= 1'b1;
                                if (dseen_reg && fdc_reg >= 4'(MAX_FRACTION_DIGITS))
                                    ;
                                else if (acc_reg > iee_pkg::ACC_LIMIT)
                                begin
                                    if (!dseen_reg)
                                        err_reg <= iee_pkg::ST_OVF;
                                end
                                else
                                begin
                                    acc_reg <= acc_x10;
                                    if (dseen_reg)
                                        fdc_reg <= fdc_reg + 1'b1;
                                end
                            end
                            iee_pkg::TK_DOT:
                            begin
                                pend_reg  <= 1'b1;
                                dseen_reg <= 1'b1;
                            end
                            iee_pkg::TK_SPACE:
                                ;
                            default:
                                state_reg <= S_CLOSE;
                        endcase
                    end
                end
                S_ENDTOK:
                begin
                    if (tok_reg.last)
                    begin
                        final_reg <= 1'b1;
                        state_reg <= S_CLOSE;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_CLOSE:
                begin
                    if (err_reg != iee_pkg::ST_OK)
                        state_reg <= final_reg ? S_OUT : S_ENDTOK;
                    else if (pend_reg)
                    begin
                        start_reg <= 1'b1;
                        req_reg   <= {iee_pkg::AR_CONV, acc_reg, iee_pkg::pow10(fdc_reg)};
                        state_reg <= S_CONV;
                    end
                    else if (final_reg)
                        state_reg <= S_FINRED;
                    else if (tok_reg.kind == iee_pkg::TK_OP)
                        state_reg <= S_OPRED;
                    else
                        state_reg <= S_ENDTOK;
                end
                S_CONV:
                begin
                    if (ar_done)
                    begin
                        pend_reg  <= 1'b0;
                        dseen_reg <= 1'b0;
                        acc_reg   <= '0;
                        fdc_reg   <= '0;
                        if (ar_rsp.status != iee_pkg::ST_OK)
                            err_reg <= ar_rsp.status;
                        else if (vcnt_reg == 2'd3)
                            err_reg <= iee_pkg::ST_OPERAND;
                        else
                        begin
                            stk0_reg <= ar_rsp.value;
                            stk1_reg <= stk0_reg;
                            stk2_reg <= stk1_reg;
                            vcnt_reg <= vcnt_reg + 1'b1;
                        end
                        // back through the close step to dispatch
                        state_reg <= S_CLOSE;
                    end
                end
                S_OPRED:
                begin
                    if (err_reg != iee_pkg::ST_OK)
                        state_reg <= S_ENDTOK;
                    else if (ocnt_reg != 2'd0 && op0_reg[1] >= tok_reg.code[1])
                        state_reg <= S_REDUCE;
                    else
                    begin
                        if (ocnt_reg == 2'd2)
                            err_reg <= iee_pkg::ST_OPERAND;
                        else
                        begin
                            op0_reg  <= tok_reg.code[1:0];
                            op1_reg  <= op0_reg;
                            ocnt_reg <= ocnt_reg + 1'b1;
                        end
                        state_reg <= S_ENDTOK;
                    end
                end
                S_FINRED:
                begin
                    if (err_reg != iee_pkg::ST_OK)
                        state_reg <= S_OUT;
                    else if (ocnt_reg != 2'd0)
                        state_reg <= S_REDUCE;
                    else
                    begin
                        if (vcnt_reg == 2'd0)
                            err_reg <= iee_pkg::ST_OPERAND;
                        state_reg <= S_OUT;
                    end
                end
                S_REDUCE:
                begin
                    op0_reg   <= op1_reg;
                    ocnt_reg  <= ocnt_reg - 1'b1;
                    state_reg <= red_ret;
                    if (vcnt_reg < 2'd2)
                        err_reg <= iee_pkg::ST_OPERAND;
                    else
                    begin
                        unique case (op0_reg)
                            iee_pkg::OP_ADD:
                            begin
                                if (add_ovf)
                                    err_reg <= iee_pkg::ST_OVF;
                                else
                                begin
                                    stk0_reg <= add_s;
                                    stk1_reg <= stk2_reg;
                                    vcnt_reg <= vcnt_reg - 1'b1;
                                end
                            end
                            iee_pkg::OP_SUB:
                            begin
                                if (sub_ovf)
                                    err_reg <= iee_pkg::ST_OVF;
                                else
                                begin
                                    stk0_reg <= sub_s;
                                    stk1_reg <= stk2_reg;
                                    vcnt_reg <= vcnt_reg - 1'b1;
                                end
                            end
                            iee_pkg::OP_MUL:
                            begin
                                start_reg <= 1'b1;
                                req_reg   <= {iee_pkg::AR_MUL, stk1_reg, stk0_reg};
                                state_reg <= S_ARITH;
                            end
                            default:
                            begin
                                start_reg <= 1'b1;
                                req_reg   <= {iee_pkg::AR_DIV, stk1_reg, stk0_reg};
                                state_reg <= S_ARITH;
                            end
                        endcase
                    end
                end
                S_ARITH:
                begin
                    if (ar_done)
                    begin
                        if (ar_rsp.status != iee_pkg::ST_OK)
                            err_reg <= ar_rsp.status;
                        else
                        begin
                            stk0_reg <= ar_rsp.value;
                            stk1_reg <= stk2_reg;
                            vcnt_reg <= vcnt_reg - 1'b1;
                        end
                        state_reg <= red_ret;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || pop)
                    begin
                        out_reg.value  <= (err_reg == iee_pkg::ST_OK) ? stk0_reg : 64'd0;
                        out_reg.status <= err_reg;
                        out_valid_reg  <= 1'b1;
                        // clear expression state for the next one
                        final_reg <= 1'b0;
                        vcnt_reg  <= '0;
                        ocnt_reg  <= '0;
                        acc_reg   <= '0;
                        fdc_reg   <= '0;
                        dseen_reg <= 1'b0;
                        pend_reg  <= 1'b0;
                        err_reg   <= iee_pkg::ST_OK;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/infix_expression_evaluator_top.sv
// Channel   Direction  Handshake          Word
// item      in         push / full        ch (8), last (1)
// result    out        empty / pop        value (64, signed Q), status (2)
//
// Spaces that do not end the expression are dropped at the front. Closing a number
// runs a conversion in the shared shift-subtract divider; a reduction does add or
// subtract in the back end and sends multiply and divide to the same unit.
// Reset returns to an empty expression; nothing needs clearing afterwards.
// A two-word queue lets the input run ahead; an unpopped result holds the back end,
// and full rises once two more words wait in the queue.
module infix_expression_evaluator_top #(
    parameter int FRACTION_BITS       = iee_pkg::FRACTION_BITS_DEF,
    parameter int MAX_FRACTION_DIGITS = iee_pkg::MAX_FRACTION_DIGITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  iee_pkg::in_word_t  item,
    output logic               empty,
    input  logic               pop,
    output iee_pkg::out_word_t result
);

    logic                q_full;
    logic                q_wr;
    iee_pkg::token_t     q_wdata;
    logic                q_rd;
    iee_pkg::token_t     q_rdata;
    logic                q_empty;
    logic                ar_start;
    iee_pkg::arith_req_t ar_req;
    logic                ar_done;
    iee_pkg::arith_rsp_t ar_rsp;

    iee_front u_front (
        .push       (push),
        .item       (item),
        .queue_full (q_full),
        .full       (full),
        .wr         (q_wr),
        .token      (q_wdata)
    );

    iee_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    iee_arith #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ar_start),
        .req   (ar_req),
        .done  (ar_done),
        .rsp   (ar_rsp)
    );

    iee_back #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_rd     (q_rd),
        .ar_start (ar_start),
        .ar_req   (ar_req),
        .ar_done  (ar_done),
        .ar_rsp   (ar_rsp),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

>>> sim/tb_infix_expression_evaluator_top.sv
module tb_infix_expression_evaluator_top;

    localparam int FRAC       = 32;
    localparam int MAX_FRAC   = 9;
    localparam int CYCLE_CAP  = 1000000;
    localparam int DRAIN_WAIT = 400;
    localparam logic [63:0] DIGIT_LIMIT = (64'hFFFF_FFFF_FFFF_FFFF - 64'd9) / 64'd10;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    iee_pkg::in_word_t  item;
    logic               empty;
    logic               pop = 1'b0;
    iee_pkg::out_word_t result;

    infix_expression_evaluator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // evaluator shadow state
    logic [63:0] val_stk [3];
    int          val_cnt;
    logic [1:0]  op_stk [2];
    int          op_cnt;
    logic [63:0] mantissa;
    int          frac_digits;
    bit          dot_seen;
    bit          num_open;
    logic [1:0]  err_code;

    iee_pkg::out_word_t expected_q [$];
    int        idle_pct;
    int        stall_pct;
    int        chars_sent;
    int        exprs_sent;
    int        results_seen  = 0;
    int        error_results = 0;
    int        mismatches    = 0;
    int        cycles        = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void eval_clear();
        val_stk     = '{64'd0, 64'd0, 64'd0};
        val_cnt     = 0;
        op_stk      = '{2'd0, 2'd0};
        op_cnt      = 0;
        mantissa    = 64'd0;
        frac_digits = 0;
        dot_seen    = 1'b0;
        num_open    = 1'b0;
        err_code    = iee_pkg::ST_OK;
    endfunction

    function automatic void flag(logic [1:0] code);
        if (err_code == iee_pkg::ST_OK)
            err_code = code;
    endfunction

    function automatic void push_val(logic [63:0] v);
        if (val_cnt >= 3)
        begin
            flag(iee_pkg::ST_OPERAND);
            return;
        end
        val_stk[val_cnt] = v;
        val_cnt++;
    endfunction

    function automatic logic [63:0] abs_val(logic [63:0] x);
        return x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] apply_sign(logic [63:0] m, bit neg);
        if (neg)
        begin
            if (m > iee_pkg::SIGN_BIT)
            begin
                flag(iee_pkg::ST_OVF);
                return 64'd0;
            end
            return 64'd0 - m;
        end
        if (m >= iee_pkg::SIGN_BIT)
        begin
            flag(iee_pkg::ST_OVF);
            return 64'd0;
        end
        return m;
    endfunction

    function automatic logic [63:0] fixed_product(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        logic [63:0]  q;
        bit           rnd;
        prod = {64'd0, abs_val(a)} * {64'd0, abs_val(b)};
        q    = prod[FRAC+63:FRAC];
        rnd  = prod[FRAC-1];
        if (prod[127:FRAC+64] != 0 || (q == '1 && rnd))
        begin
            flag(iee_pkg::ST_OVF);
            return 64'd0;
        end
        return apply_sign(q + {63'd0, rnd}, a[63] ^ b[63]);
    endfunction

    function automatic logic [63:0] fixed_quotient(logic [63:0] a, logic [63:0] b);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        logic [63:0]  ub;
        ub = abs_val(b);
        if (ub == 64'd0)
        begin
            flag(iee_pkg::ST_DIV0);
            return 64'd0;
        end
        num = {64'd0, abs_val(a)} << FRAC;
        q   = num / ub;
        r   = num % ub;
        if (q[127:64] != 0)
        begin
            flag(iee_pkg::ST_OVF);
            return 64'd0;
        end
        if ((r << 1) >= ub)
        begin
            if (q[63:0] == '1)
            begin
                flag(iee_pkg::ST_OVF);
                return 64'd0;
            end
            q++;
        end
        return apply_sign(q[63:0], a[63] ^ b[63]);
    endfunction

    function automatic void reduce_top();
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] s;
        logic [1:0]  op;
        if (op_cnt == 0)
            return;
        op_cnt--;
        op = op_stk[op_cnt];
        if (val_cnt < 2)
        begin
            flag(iee_pkg::ST_OPERAND);
            return;
        end
        b = val_stk[val_cnt-1];
        a = val_stk[val_cnt-2];
        val_cnt -= 2;
        case (op)
            iee_pkg::OP_ADD:
            begin
                s = a + b;
                if (a[63] == b[63] && s[63] != a[63])
                begin
                    flag(iee_pkg::ST_OVF);
                    s = 64'd0;
                end
            end
            iee_pkg::OP_SUB:
            begin
                s = a - b;
                if (a[63] != b[63] && s[63] != a[63])
                begin
                    flag(iee_pkg::ST_OVF);
                    s = 64'd0;
                end
            end
            iee_pkg::OP_MUL: s = fixed_product(a, b);
            default:         s = fixed_quotient(a, b);
        endcase
        push_val(s);
    endfunction

    function automatic void close_num();
        logic [63:0]  p;
        logic [63:0]  ip;
        logic [127:0] rem;
        logic [63:0]  frac;
        logic [63:0]  v;
        if (!num_open)
            return;
        p = 64'd1;
        for (int k = 0; k < frac_digits; k++)
            p = p * 64'd10;
        ip   = mantissa / p;
        rem  = {64'd0, mantissa % p} << FRAC;
        frac = 64'(rem / {64'd0, p});
        rem  = rem % {64'd0, p};
        if ((rem << 1) >= {64'd0, p})
            frac++;
        num_open    = 1'b0;
        dot_seen    = 1'b0;
        mantissa    = 64'd0;
        frac_digits = 0;
        if ((ip >> (63 - FRAC)) != 0)
        begin
            flag(iee_pkg::ST_OVF);
            return;
        end
        v = (ip << FRAC) + frac;
        if (v >= iee_pkg::SIGN_BIT)
        begin
            flag(iee_pkg::ST_OVF);
            return;
        end
        push_val(v);
    endfunction

    function automatic void take_char(logic [7:0] c);
        logic [1:0] code;
        if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE)
        begin
            num_open = 1'b1;
            if (dot_seen && frac_digits >= MAX_FRAC)
                return;
            if (mantissa > DIGIT_LIMIT)
            begin
                if (!dot_seen)
                    flag(iee_pkg::ST_OVF);
                return;
            end
            mantissa = mantissa * 64'd10 + {56'd0, c - iee_pkg::CH_ZERO};
            if (dot_seen)
                frac_digits++;
        end
        else if (c == iee_pkg::CH_DOT)
        begin
            num_open = 1'b1;
            dot_seen = 1'b1;
        end
        else if (c != iee_pkg::CH_SPACE)
        begin
            close_num();
            case (c)
                iee_pkg::CH_PLUS:  code = iee_pkg::OP_ADD;
                iee_pkg::CH_MINUS: code = iee_pkg::OP_SUB;
                iee_pkg::CH_STAR:  code = iee_pkg::OP_MUL;
                iee_pkg::CH_SLASH: code = iee_pkg::OP_DIV;
                default:           return;
            endcase
            while (err_code == iee_pkg::ST_OK && op_cnt > 0 && op_stk[op_cnt-1][1] >= code[1])
                reduce_top();
            if (err_code != iee_pkg::ST_OK)
                return;
            if (op_cnt >= 2)
            begin
                flag(iee_pkg::ST_OPERAND);
                return;
            end
            op_stk[op_cnt] = code;
            op_cnt++;
        end
    endfunction

    // advance the shadow evaluator by one accepted word
    function automatic void evaluate_word(iee_pkg::in_word_t w);
        iee_pkg::out_word_t r;
        if (err_code == iee_pkg::ST_OK)
            take_char(w.ch);
        if (!w.last)
            return;
        if (err_code == iee_pkg::ST_OK)
            close_num();
        while (err_code == iee_pkg::ST_OK && op_cnt > 0)
            reduce_top();
        if (err_code == iee_pkg::ST_OK && val_cnt == 0)
            flag(iee_pkg::ST_OPERAND);
        r.status = err_code;
        r.value  = (err_code == iee_pkg::ST_OK) ? val_stk[val_cnt-1] : 64'd0;
        expected_q.push_back(r);
        eval_clear();
    endfunction

    task automatic send_word(logic [7:0] c, bit is_last);
        iee_pkg::in_word_t w;
        w.ch   = c;
        w.last = is_last;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        evaluate_word(w);
        chars_sent++;
    endtask

    task automatic send_expr(byte unsigned text [$]);
        if (text.size() == 0)
            text.push_back(iee_pkg::CH_SPACE);
        foreach (text[i])
            send_word(text[i], i == text.size() - 1);
        exprs_sent++;
    endtask

    task automatic send_str(string s);
        byte unsigned text [$];
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_expr(text);
    endtask

    task automatic add_number(ref byte unsigned text [$]);
        int int_len;
        int frac_len;
        int_len = ($urandom_range(19) == 0) ? $urandom_range(8, 21) : $urandom_range(0, 3);
        if ($urandom_range(9) == 0)
            text.push_back(iee_pkg::CH_ZERO);
        else
            for (int i = 0; i < int_len + 1; i++)
                text.push_back(8'(iee_pkg::CH_ZERO + $urandom_range(9)));
        if ($urandom_range(2) == 0)
        begin
            text.push_back(iee_pkg::CH_DOT);
            frac_len = $urandom_range(4) == 0 ? $urandom_range(12) : $urandom_range(3);
            for (int i = 0; i < frac_len; i++)
            begin
                text.push_back(8'(iee_pkg::CH_ZERO + $urandom_range(9)));
                if ($urandom_range(30) == 0)
                    text.push_back($urandom_range(1) ? iee_pkg::CH_DOT : iee_pkg::CH_SPACE);
            end
        end
        if ($urandom_range(5) == 0)
            text.push_back(iee_pkg::CH_SPACE);
    endtask

    task automatic send_random_expr();
        byte unsigned text [$];
        byte unsigned ops [4];
        int terms;
        ops = '{iee_pkg::CH_PLUS, iee_pkg::CH_MINUS, iee_pkg::CH_STAR, iee_pkg::CH_SLASH};
        if ($urandom_range(99) < 12)
        begin
            // noise: raw bytes, malformed sequences
            repeat ($urandom_range(1, 8))
                text.push_back(8'($urandom_range(255)));
        end
        else
        begin
            terms = $urandom_range(1, 4);
            for (int t = 0; t < terms; t++)
            begin
                if (t > 0)
                    text.push_back(ops[$urandom_range(3)]);
                add_number(text);
            end
            if ($urandom_range(15) == 0)
                text.push_back(ops[$urandom_range(3)]);
        end
        send_expr(text);
    endtask

    task automatic test_basic_ops();
        send_str("1+2");
        send_str("7-9.5");
        send_str("2.5*4");
        send_str("1/3");
    endtask

    task automatic test_error_cases();
        send_str("7/0");
        send_str("-5");
        send_str(" ");
        send_str("1a2a3a4");
        send_str("2147483647*2");
    endtask

    task automatic test_number_forms();
        send_str("1..5");
        send_str("0.1234567891");
        send_str("99999999999999999999");
        send_str("2147483648");
        send_str("1 2z7");
        send_str("..");
    endtask

    task automatic test_random(int target, int idle, int stall, bit drain_first);
        int stop_at;
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = chars_sent + target;
        while (chars_sent < stop_at)
        begin
            send_random_expr();
            // with drain_first set, hold the sender on about one pass in four until every result is back
            if (drain_first && $urandom_range(3) == 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                wait (expected_q.size() == 0);
            end
        end
    endtask

    always @(negedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        iee_pkg::out_word_t exp_w;
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word: value=%0h status=%0d",
                       result.value, result.status);
                mismatches++;
            end
            else
            begin
                exp_w = expected_q.pop_front();
                if (exp_w.status != iee_pkg::ST_OK)
                    error_results++;
                if (result.value !== exp_w.value)
                begin
                    $error("value: expected %0h, got %0h", exp_w.value, result.value);
                    mismatches++;
                end
                if (result.status !== exp_w.status)
                begin
                    $error("status: expected %0d, got %0d", exp_w.status, result.status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int drain;
        rst_n         = 1'b0;
        push          = 1'b0;
        item          = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        chars_sent    = 0;
        exprs_sent    = 0;
        eval_clear();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_error_cases();
        test_number_forms();
        test_random(110, 0, 0, 1'b0);
        test_random(110, 78, 0, 1'b1);
        test_random(110, 0, 78, 1'b0);
        test_random(110, 27, 27, 1'b0);

        @(negedge clk);
        push <= 1'b0;
        drain = 0;
        while (expected_q.size() != 0 && drain < 200000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d characters in %0d expressions under four idle/stall mixes;",
                 chars_sent, exprs_sent);
        $display("%0d results checked, %0d of them with an error status.",
                 results_seen, error_results);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
